[hw/rtl/space_vector_pwm_compare_gen_defines.svh]
// assertion macros for the space vector pwm compare generator
`ifndef SPACE_VECTOR_PWM_COMPARE_GEN_DEFINES_SVH
`define SPACE_VECTOR_PWM_COMPARE_GEN_DEFINES_SVH

// condition must hold at every clock edge outside reset
`define SVPWM_ASSERT_HOLDS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define SVPWM_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

[hw/rtl/svpwm_pkg.sv]
// shared types and constants of the space vector pwm compare generator
`default_nettype none

package svpwm_pkg;

   // fixed point constants
   localparam int QSHIFT = 15;
   localparam int HPW = 15;            // half period width
   localparam int VW = 18;             // projection width
   localparam int TW = 20;             // switching time width
   localparam int PW = TW + HPW + 1;   // scaled product width
   localparam int SW = PW - QSHIFT;    // shifted product width

   localparam logic signed [15:0] SQRT3_HALF_Q15 = 16'sd28378;
   localparam logic signed [TW-1:0] ONE_Q15 = TW'(32767);

   // configuration register indexes
   localparam logic CSR_HALF_PERIOD = 1'b0;
   localparam logic CSR_MODE = 1'b1;

   localparam logic [HPW-1:0] HALF_PERIOD_RESET = 15'd1500;

   // modulation modes
   localparam logic [1:0] MODE_SEVEN = 2'd0;
   localparam logic [1:0] MODE_FIVE = 2'd1;

   // sector codes from the three projection signs
   localparam logic [2:0] SECTOR_NONE = 3'd0;
   localparam logic [2:0] SECTOR_1 = 3'd1;
   localparam logic [2:0] SECTOR_2 = 3'd2;
   localparam logic [2:0] SECTOR_3 = 3'd3;
   localparam logic [2:0] SECTOR_4 = 3'd4;
   localparam logic [2:0] SECTOR_5 = 3'd5;
   localparam logic [2:0] SECTOR_6 = 3'd6;
   localparam logic [2:0] SECTOR_ALL = 3'd7;

   // input beat, packed as on the bus
   typedef struct packed {
      logic signed [15:0] v_beta;
      logic signed [15:0] v_alpha;
   } ref_type;

   // three reference projections and the sector code
   typedef struct packed {
      logic [2:0]            sector;
      logic signed [VW-1:0]  v1;
      logic signed [VW-1:0]  v2;
      logic signed [VW-1:0]  v3;
   } proj_type;

   // unscaled switching times
   typedef struct packed {
      logic [2:0]            sector;
      logic signed [TW-1:0]  ta;
      logic signed [TW-1:0]  tb;
      logic signed [TW-1:0]  tc;
   } time_type;

   // result beat, packed as on the bus
   typedef struct packed {
      logic [2:0]      sector_code;
      logic [HPW-1:0]  compare_c;
      logic [HPW-1:0]  compare_b;
      logic [HPW-1:0]  compare_a;
   } result_type;

endpackage

`default_nettype wire

[hw/rtl/svpwm_proj.sv]
// projection stages: alpha product, then the three projections and sector code
`default_nettype none

module svpwm_proj
   import svpwm_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      in_valid,
   output logic           in_ready,
   input  wire ref_type   in_data,
   output logic           out_valid,
   input  wire logic      out_ready,
   output proj_type       out_data
);

   logic                 p1_valid_ff;
   logic signed [31:0]   p1_prod_ff;
   logic signed [31:0]   p1_prod_in;
   logic signed [15:0]   p1_beta_ff;
   logic                 p1_ready;

   logic                 p2_valid_ff;
   proj_type             p2_data_ff;
   proj_type             p2_data_in;
   logic                 p2_ready;

   logic signed [VW-1:0] pa;
   logic signed [VW-1:0] pb;
   logic signed [15:0]   beta_half;

   // ready chain: a stage takes a beat when empty or draining
   assign p2_ready = !p2_valid_ff || out_ready;
   assign p1_ready = !p1_valid_ff || p2_ready;
   assign in_ready = p1_ready;

   // sqrt(3)/2 times alpha
   assign p1_prod_in = SQRT3_HALF_Q15 * in_data.v_alpha;

   // floor shifts and projections
   always_comb begin
      beta_half = p1_beta_ff >>> 1;
      pa = {{(VW-17){p1_prod_ff[31]}}, p1_prod_ff[31:QSHIFT]};
      pb = {{(VW-16){beta_half[15]}}, beta_half};
      p2_data_in.v1 = {{(VW-16){p1_beta_ff[15]}}, p1_beta_ff};
      p2_data_in.v2 = pa - pb;
      p2_data_in.v3 = -pa - pb;
      p2_data_in.sector = {~p2_data_in.v3[VW-1], ~p2_data_in.v2[VW-1],
                           ~p2_data_in.v1[VW-1]};
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
      end else begin
         if (p1_ready) begin
            p1_valid_ff <= in_valid;
         end
         if (p2_ready) begin
            p2_valid_ff <= p1_valid_ff;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (in_valid && p1_ready) begin
         p1_prod_ff <= p1_prod_in;
         p1_beta_ff <= in_data.v_beta;
      end
      if (p1_valid_ff && p2_ready) begin
         p2_data_ff <= p2_data_in;
      end
   end

   assign out_valid = p2_valid_ff;
   assign out_data = p2_data_ff;

endmodule

`default_nettype wire

[hw/rtl/svpwm_time.sv]
// time stage: active vector times by sector and the switching times ta, tb, tc
`default_nettype none

module svpwm_time
   import svpwm_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      in_valid,
   output logic           in_ready,
   input  wire proj_type  in_data,
   output logic           out_valid,
   input  wire logic      out_ready,
   output time_type       out_data
);

   logic                 valid_ff;
   time_type             data_ff;
   time_type             data_in;
   logic signed [VW-1:0] t1;
   logic signed [VW-1:0] t2;
   logic signed [TW-1:0] t1_x;
   logic signed [TW-1:0] t2_x;
   logic signed [TW-1:0] rest;

   assign in_ready = !valid_ff || out_ready;

   // active vector times picked by sector
   always_comb begin
      unique case (in_data.sector)
         SECTOR_1: begin
            t1 = -in_data.v3;
            t2 = -in_data.v2;
         end
         SECTOR_2: begin
            t1 = -in_data.v1;
            t2 = -in_data.v3;
         end
         SECTOR_3: begin
            t1 = in_data.v1;
            t2 = in_data.v2;
         end
         SECTOR_4: begin
            t1 = -in_data.v2;
            t2 = -in_data.v1;
         end
         SECTOR_5: begin
            t1 = in_data.v3;
            t2 = in_data.v1;
         end
         SECTOR_6: begin
            t1 = in_data.v2;
            t2 = in_data.v3;
         end
         default: begin
            t1 = '0;
            t2 = '0;
         end
      endcase
   end

   // switching times
   always_comb begin
      t1_x = {{(TW-VW){t1[VW-1]}}, t1};
      t2_x = {{(TW-VW){t2[VW-1]}}, t2};
      rest = ONE_Q15 - t1_x - t2_x;
      data_in.sector = in_data.sector;
      data_in.ta = rest >>> 1;
      data_in.tb = data_in.ta + t1_x;
      data_in.tc = data_in.tb + t2_x;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data = data_ff;

endmodule

`default_nettype wire

[hw/rtl/svpwm_scale.sv]
// scale stages: multiply by half period, then clamp and map to phases
`default_nettype none

module svpwm_scale
   import svpwm_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic [HPW-1:0]  half_period,
   input  wire logic [1:0]      modulation_mode,
   input  wire logic            in_valid,
   output logic                 in_ready,
   input  wire time_type        in_data,
   output logic                 out_valid,
   input  wire logic            out_ready,
   output result_type           out_data
);

   logic                 s1_valid_ff;
   logic [2:0]           s1_sector_ff;
   logic signed [PW-1:0] s1_prod_a_ff;
   logic signed [PW-1:0] s1_prod_b_ff;
   logic signed [PW-1:0] s1_prod_c_ff;
   logic signed [PW-1:0] s1_prod_a_in;
   logic signed [PW-1:0] s1_prod_b_in;
   logic signed [PW-1:0] s1_prod_c_in;
   logic signed [15:0]   hp_s;
   logic                 s1_ready;

   logic                 s2_valid_ff;
   result_type           s2_data_ff;
   result_type           s2_data_in;
   logic                 s2_ready;

   logic [HPW-1:0]       ta_c;
   logic [HPW-1:0]       tb_c;
   logic [HPW-1:0]       tc_c;
   logic [HPW-1:0]       base;
   logic [HPW-1:0]       xa;
   logic [HPW-1:0]       xb;
   logic [HPW-1:0]       xc;

   // floor shift of the scaled time, clamped to 0..half_period-1
   function automatic logic [HPW-1:0] clamp_time(input logic signed [PW-1:0] prod,
                                                input logic [HPW-1:0] hp);
      logic signed [SW-1:0] s;
      logic signed [SW-1:0] hp_x;
      s = prod[PW-1:QSHIFT];
      hp_x = $signed({{(SW-HPW){1'b0}}, hp});
      if (s >= hp_x) begin
         clamp_time = (hp == '0) ? '0 : hp - 1'b1;
      end else if (s[SW-1] || s == '0) begin
         clamp_time = '0;
      end else begin
         clamp_time = s[HPW-1:0];
      end
   endfunction

   assign s2_ready = !s2_valid_ff || out_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   // time times half period
   assign hp_s = $signed({1'b0, half_period});
   assign s1_prod_a_in = in_data.ta * hp_s;
   assign s1_prod_b_in = in_data.tb * hp_s;
   assign s1_prod_c_in = in_data.tc * hp_s;

   // clamp, optional five segment offset, phase mapping; other modes give zero compares
   always_comb begin
      ta_c = clamp_time(s1_prod_a_ff, half_period);
      tb_c = clamp_time(s1_prod_b_ff, half_period);
      tc_c = clamp_time(s1_prod_c_ff, half_period);
      base = (modulation_mode == MODE_FIVE) ? ta_c : '0;
      xa = ta_c - base;
      xb = tb_c - base;
      xc = tc_c - base;
      s2_data_in.sector_code = s1_sector_ff;
      s2_data_in.compare_a = '0;
      s2_data_in.compare_b = '0;
      s2_data_in.compare_c = '0;
      if (modulation_mode == MODE_SEVEN || modulation_mode == MODE_FIVE) begin
         unique case (s1_sector_ff)
            SECTOR_1: begin
               s2_data_in.compare_a = xb;
               s2_data_in.compare_b = xc;
               s2_data_in.compare_c = xa;
            end
            SECTOR_2: begin
               s2_data_in.compare_a = xc;
               s2_data_in.compare_b = xa;
               s2_data_in.compare_c = xb;
            end
            SECTOR_3: begin
               s2_data_in.compare_a = xc;
               s2_data_in.compare_b = xb;
               s2_data_in.compare_c = xa;
            end
            SECTOR_4: begin
               s2_data_in.compare_a = xa;
               s2_data_in.compare_b = xb;
               s2_data_in.compare_c = xc;
            end
            SECTOR_5: begin
               s2_data_in.compare_a = xa;
               s2_data_in.compare_b = xc;
               s2_data_in.compare_c = xb;
            end
            SECTOR_6: begin
               s2_data_in.compare_a = xb;
               s2_data_in.compare_b = xa;
               s2_data_in.compare_c = xc;
            end
            default: begin
               s2_data_in.compare_a = '0;
               s2_data_in.compare_b = '0;
               s2_data_in.compare_c = '0;
            end
         endcase
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= in_valid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (in_valid && s1_ready) begin
         s1_sector_ff <= in_data.sector;
         s1_prod_a_ff <= s1_prod_a_in;
         s1_prod_b_ff <= s1_prod_b_in;
         s1_prod_c_ff <= s1_prod_c_in;
      end
      if (s1_valid_ff && s2_ready) begin
         s2_data_ff <= s2_data_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_data = s2_data_ff;

endmodule

`default_nettype wire

[hw/rtl/space_vector_pwm_compare_gen.sv]
// five register stages from an accepted req beat to the rsp beat
// throughput: one beat per cycle while rsp_tready is high; each stage has its own valid bit and ready term
// a stalled rsp beat does not block req until the stages behind it fill up
// reset clears all valid bits, half_period to 1500 and modulation_mode to seven segment
// config is registered from csr writes and is read by the scale stages
`default_nettype none

`include "space_vector_pwm_compare_gen_defines.svh"

module space_vector_pwm_compare_gen
   import svpwm_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   // request beat
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [31:0]  req_tdata,   // v_alpha[15:0], v_beta[31:16]
   // response beat
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [47:0]       rsp_tdata,   // compare_a[14:0], compare_b[29:15],
                                          // compare_c[44:30], sector_code[47:45]
   // configuration writes
   input  wire logic         csr_wr_en,
   input  wire logic         csr_index,
   input  wire logic [14:0]  csr_wdata
);

   logic [HPW-1:0] half_period_ff;
   logic [1:0]     mode_ff;

   ref_type        req_item;
   proj_type       proj_data;
   time_type       time_data;
   result_type     rsp_item;
   logic           proj_valid;
   logic           proj_ready;
   logic           time_valid;
   logic           time_ready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff <= HALF_PERIOD_RESET;
         mode_ff <= MODE_SEVEN;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_HALF_PERIOD: half_period_ff <= csr_wdata;
            CSR_MODE:        mode_ff <= csr_wdata[1:0];
            default:         mode_ff <= mode_ff;
         endcase
      end
   end

   assign req_item = req_tdata;

   // projections and sector
   svpwm_proj u_proj (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (req_item),
      .out_valid (proj_valid),
      .out_ready (proj_ready),
      .out_data  (proj_data)
   );

   // switching times
   svpwm_time u_time (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (proj_valid),
      .in_ready  (proj_ready),
      .in_data   (proj_data),
      .out_valid (time_valid),
      .out_ready (time_ready),
      .out_data  (time_data)
   );

   // scaling, clamping and phase mapping
   svpwm_scale u_scale (
      .clock           (clock),
      .reset           (reset),
      .half_period     (half_period_ff),
      .modulation_mode (mode_ff),
      .in_valid        (time_valid),
      .in_ready        (time_ready),
      .in_data         (time_data),
      .out_valid       (rsp_tvalid),
      .out_ready       (rsp_tready),
      .out_data        (rsp_item)
   );

   assign rsp_tdata = rsp_item;

   // checks
   `SVPWM_ASSERT_IMPLIES(a_null_sector_zero,
      rsp_tvalid && (rsp_item.sector_code == SECTOR_NONE || rsp_item.sector_code == SECTOR_ALL),
      rsp_item.compare_a == '0 && rsp_item.compare_b == '0 && rsp_item.compare_c == '0,
      "null sector gave a nonzero compare")
   `SVPWM_ASSERT_HOLDS(a_empty_pipe_ready, rsp_tvalid || req_tready,
      "req not ready while the response side is empty")
   `SVPWM_ASSERT_IMPLIES(a_reset_clears_rsp, $past(reset), !rsp_tvalid,
      "response valid right after reset")

endmodule

`default_nettype wire
